// ===== sv/phj_pkg.sv =====
`default_nettype none
package phj_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int WORD_WIDTH = 32;

  localparam int FOCAL_W = WORD_WIDTH - 1;
  localparam int QUO_W   = WORD_WIDTH + 2;
  localparam int DEN_W   = 2 * WORD_WIDTH;
  localparam int NUM_W   = 2 * WORD_WIDTH + FRAC_BITS;
  localparam int SUM_W   = QUO_W + 3;
  localparam int LANES   = 6;

  // Lane order of the six quotients.
  localparam int L_U   = 0;
  localparam int L_V   = 1;
  localparam int L_JUX = 2;
  localparam int L_JUZ = 3;
  localparam int L_JVY = 4;
  localparam int L_JVZ = 5;

  localparam int CFG_IDX_W = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FOCAL_X  = 4'd0,
    REG_FOCAL_Y  = 4'd1,
    REG_CENTER_X = 4'd2,
    REG_CENTER_Y = 4'd3
  } phj_reg_t;

  localparam logic [FOCAL_W-1:0]    FOCAL_X_RST  = FOCAL_W'(32768000);
  localparam logic [FOCAL_W-1:0]    FOCAL_Y_RST  = FOCAL_W'(32768000);
  localparam logic [WORD_WIDTH-1:0] CENTER_X_RST = WORD_WIDTH'(20971520);
  localparam logic [WORD_WIDTH-1:0] CENTER_Y_RST = WORD_WIDTH'(15728640);

  typedef struct packed {
    logic             zero;
    logic [LANES-1:0] neg;
  } phj_side_t;

  typedef struct packed {
    logic             big;
    logic [QUO_W-1:0] quo;
  } phj_quo_t;

endpackage
`default_nettype wire

// ===== sv/phj_intf.sv =====
`default_nettype none
interface phj_point_if import phj_pkg::*; ();
  logic                         valid;
  logic                         ready;
  logic signed [WORD_WIDTH-1:0] point_x;
  logic signed [WORD_WIDTH-1:0] point_y;
  logic signed [WORD_WIDTH-1:0] point_z;

  modport source (output valid, output point_x, output point_y, output point_z,
                  input ready);
  modport sink (input valid, input point_x, input point_y, input point_z,
                output ready);
endinterface

interface phj_result_if import phj_pkg::*; ();
  logic                         valid;
  logic                         ready;
  logic signed [WORD_WIDTH-1:0] pixel_u;
  logic signed [WORD_WIDTH-1:0] pixel_v;
  logic signed [WORD_WIDTH-1:0] du_dx;
  logic signed [WORD_WIDTH-1:0] du_dz;
  logic signed [WORD_WIDTH-1:0] dv_dy;
  logic signed [WORD_WIDTH-1:0] dv_dz;
  logic                         depth_zero;
  logic                         saturated;

  modport source (output valid, output pixel_u, output pixel_v, output du_dx,
                  output du_dz, output dv_dy, output dv_dz, output depth_zero,
                  output saturated, input ready);
  modport sink (input valid, input pixel_u, input pixel_v, input du_dx,
                input du_dz, input dv_dy, input dv_dz, input depth_zero,
                input saturated, output ready);
endinterface

interface phj_cfg_if import phj_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [WORD_WIDTH-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ===== sv/phj_front.sv =====
`default_nettype none
module phj_front import phj_pkg::*; (
  input  wire logic                             clk,
  input  wire logic                             rst,
  phj_point_if.sink                             point,
  input  wire logic [FOCAL_W-1:0]               focal_x,
  input  wire logic [FOCAL_W-1:0]               focal_y,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic [LANES-1:0][NUM_W-1:0]           num,
  output logic [LANES-1:0][DEN_W-1:0]           den,
  output phj_side_t                             side
);

  logic v0, v1, v2;
  logic en0, en1, en2;

  logic [WORD_WIDTH-1:0] x0, y0, z0;
  logic [WORD_WIDTH-1:0] ax1, ay1, az1;
  phj_side_t             side1, side2;
  logic [DEN_W-1:0]      px2, py2, z2sq;
  logic [WORD_WIDTH-1:0] az2;

  logic [WORD_WIDTH-1:0] ax_next, ay_next, az_next;
  phj_side_t             side_next;
  logic                  xn, yn, zn;

  assign en2 = !v2 || out_ready;
  assign en1 = !v1 || en2;
  assign en0 = !v0 || en1;
  assign point.ready = en0;

  always_comb begin
    xn = x0[WORD_WIDTH-1];
    yn = y0[WORD_WIDTH-1];
    zn = z0[WORD_WIDTH-1];
    ax_next = xn ? (~x0 + 1'b1) : x0;
    ay_next = yn ? (~y0 + 1'b1) : y0;
    az_next = zn ? (~z0 + 1'b1) : z0;
    side_next.zero       = (z0 == '0);
    side_next.neg        = '0;
    side_next.neg[L_U]   = xn ^ zn;
    side_next.neg[L_V]   = yn ^ zn;
    side_next.neg[L_JUX] = zn;
    side_next.neg[L_JUZ] = !xn;
    side_next.neg[L_JVY] = zn;
    side_next.neg[L_JVZ] = !yn;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      if (en0) v0 <= point.valid;
      if (en1) v1 <= v0;
      if (en2) v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en0 && point.valid) begin
      x0 <= point.point_x;
      y0 <= point.point_y;
      z0 <= point.point_z;
    end
    if (en1 && v0) begin
      ax1   <= ax_next;
      ay1   <= ay_next;
      az1   <= az_next;
      side1 <= side_next;
    end
    if (en2 && v1) begin
      px2   <= DEN_W'(focal_x) * DEN_W'(ax1);
      py2   <= DEN_W'(focal_y) * DEN_W'(ay1);
      z2sq  <= DEN_W'(az1) * DEN_W'(az1);
      az2   <= az1;
      side2 <= side1;
    end
  end

  always_comb begin
    num[L_U]   = NUM_W'(px2);
    den[L_U]   = DEN_W'(az2);
    num[L_V]   = NUM_W'(py2);
    den[L_V]   = DEN_W'(az2);
    num[L_JUX] = NUM_W'(focal_x) << FRAC_BITS;
    den[L_JUX] = DEN_W'(az2);
    num[L_JUZ] = NUM_W'(px2) << FRAC_BITS;
    den[L_JUZ] = z2sq;
    num[L_JVY] = NUM_W'(focal_y) << FRAC_BITS;
    den[L_JVY] = DEN_W'(az2);
    num[L_JVZ] = NUM_W'(py2) << FRAC_BITS;
    den[L_JVZ] = z2sq;
  end

  assign out_valid = v2;
  assign side      = side2;

endmodule
`default_nettype wire

// ===== sv/phj_div.sv =====
`default_nettype none
module phj_div import phj_pkg::*; (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [LANES-1:0][NUM_W-1:0]  num,
  input  wire logic [LANES-1:0][DEN_W-1:0]  den,
  input  wire phj_side_t                    in_side,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output phj_quo_t [LANES-1:0]              quo,
  output phj_side_t                         out_side
);

  // Rank 0 screens for quotients too large to hold, rank k holds k quotient bits.
  logic [QUO_W:0]                          v;
  logic [QUO_W:0]                          en;
  logic [QUO_W-1:0][LANES-1:0][DEN_W-1:0]  rem;
  logic [QUO_W-1:0][LANES-1:0][DEN_W-1:0]  dv;
  logic [QUO_W:0][LANES-1:0][QUO_W-1:0]    sh;
  logic [QUO_W:0][LANES-1:0]               big;
  phj_side_t [QUO_W:0]                     sd;

  assign en[QUO_W] = !v[QUO_W] || out_ready;
  assign in_ready  = en[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v[0] <= 1'b0;
    end else if (en[0]) begin
      v[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en[0] && in_valid) begin
      for (int l = 0; l < LANES; l++) begin
        big[0][l] <= DEN_W'(num[l][NUM_W-1:QUO_W]) >= den[l];
        rem[0][l] <= DEN_W'(num[l][NUM_W-1:QUO_W]);
        sh[0][l]  <= num[l][QUO_W-1:0];
        dv[0][l]  <= den[l];
      end
      sd[0] <= in_side;
    end
  end

  for (genvar k = 1; k <= QUO_W; k++) begin : g_step
    logic [LANES-1:0][DEN_W:0]   trial;
    logic [LANES-1:0]            ge;
    logic [LANES-1:0][DEN_W-1:0] rem_next;

    assign en[k-1] = !v[k-1] || en[k];

    always_comb begin
      for (int l = 0; l < LANES; l++) begin
        trial[l]    = {rem[k-1][l], sh[k-1][l][QUO_W-1]};
        ge[l]       = trial[l] >= {1'b0, dv[k-1][l]};
        rem_next[l] = ge[l] ? DEN_W'(trial[l] - {1'b0, dv[k-1][l]}) : DEN_W'(trial[l]);
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k] <= 1'b0;
      end else if (en[k]) begin
        v[k] <= v[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en[k] && v[k-1]) begin
        for (int l = 0; l < LANES; l++) begin
          sh[k][l] <= {sh[k-1][l][QUO_W-2:0], ge[l]};
        end
        big[k] <= big[k-1];
        sd[k]  <= sd[k-1];
      end
    end

    if (k < QUO_W) begin : g_carry
      always_ff @(posedge clk) begin
        if (en[k] && v[k-1]) begin
          rem[k] <= rem_next;
          dv[k]  <= dv[k-1];
        end
      end
    end
  end

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      quo[l].big = big[QUO_W][l];
      quo[l].quo = sh[QUO_W][l];
    end
  end

  assign out_valid = v[QUO_W];
  assign out_side  = sd[QUO_W];

endmodule
`default_nettype wire

// ===== sv/phj_back.sv =====
`default_nettype none
module phj_back import phj_pkg::*; (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire phj_quo_t [LANES-1:0]   quo,
  input  wire phj_side_t              side,
  input  wire logic [WORD_WIDTH-1:0]  center_x,
  input  wire logic [WORD_WIDTH-1:0]  center_y,
  phj_result_if.source                result
);

  logic                                en;
  logic                                valid;
  logic [LANES-1:0][WORD_WIDTH-1:0]    word;
  logic                                zero;
  logic                                sat;

  logic [LANES-1:0][WORD_WIDTH-1:0]    ctr;
  logic [LANES-1:0][QUO_W:0]           qx;
  logic [LANES-1:0][SUM_W-1:0]         sv;
  logic [LANES-1:0][SUM_W-1:0]         sum;
  logic [LANES-1:0]                    ovf;
  logic [LANES-1:0][WORD_WIDTH-1:0]    word_next;

  assign en       = !valid || result.ready;
  assign in_ready = en;

  always_comb begin
    ctr       = '0;
    ctr[L_U]  = center_x;
    ctr[L_V]  = center_y;
    for (int l = 0; l < LANES; l++) begin
      // Any quotient past the held range saturates whatever the center is.
      qx[l]  = quo[l].big ? {1'b1, {QUO_W{1'b0}}} : {1'b0, quo[l].quo};
      sv[l]  = side.neg[l] ? (SUM_W'(0) - SUM_W'(qx[l])) : SUM_W'(qx[l]);
      sum[l] = sv[l] + {{(SUM_W-WORD_WIDTH){ctr[l][WORD_WIDTH-1]}}, ctr[l]};
      ovf[l] = (sum[l][SUM_W-1:WORD_WIDTH-1] != '0) &&
               (sum[l][SUM_W-1:WORD_WIDTH-1] != '1);
      if (ovf[l]) begin
        word_next[l] = sum[l][SUM_W-1] ? {1'b1, {(WORD_WIDTH-1){1'b0}}}
                                       : {1'b0, {(WORD_WIDTH-1){1'b1}}};
      end else begin
        word_next[l] = sum[l][WORD_WIDTH-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en && in_valid) begin
      zero <= side.zero;
      if (side.zero) begin
        word <= '0;
        sat  <= 1'b0;
      end else begin
        word <= word_next;
        sat  <= |ovf;
      end
    end
  end

  assign result.valid      = valid;
  assign result.pixel_u    = word[L_U];
  assign result.pixel_v    = word[L_V];
  assign result.du_dx      = word[L_JUX];
  assign result.du_dz      = word[L_JUZ];
  assign result.dv_dy      = word[L_JVY];
  assign result.dv_dz      = word[L_JVZ];
  assign result.depth_zero = zero;
  assign result.saturated  = sat;

endmodule
`default_nettype wire

// ===== sv/pinhole_project_with_jacobian_top.sv =====
// Pinhole projection of one camera-frame point per word, with the Jacobian.
// The point channel takes x, y, z in signed Q16.16; the result channel gives
// pixel u and v, the four nonzero Jacobian entries, a zero-depth flag and a
// saturation flag. Both channels move a word when valid and ready are high.
// The configuration channel is always ready and writes focal_x, focal_y,
// center_x and center_y by index; write it only while no point is in flight.
// Throughput is one point per cycle while the receiver is ready. A point goes
// from acceptance to result valid through three front ranks (input, magnitude,
// multiply), 35 ranks of the six parallel long dividers (one range check, then
// one quotient bit per rank over 34 bits) and the output register.
// Each rank moves forward when it is empty or the rank after it moves, so
// bubbles close up; a stalled receiver holds the output word and the stages
// behind it fill before the point channel drops ready. Nothing is lost or
// repeated. Synchronous reset empties the pipeline and restores the register
// defaults (500.0, 500.0, 320.0, 240.0).
`default_nettype none
module pinhole_project_with_jacobian_top import phj_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst,
  phj_point_if.sink    point,
  phj_result_if.source result,
  phj_cfg_if.sink      cfg
);

  logic [FOCAL_W-1:0]    focal_x;
  logic [FOCAL_W-1:0]    focal_y;
  logic [WORD_WIDTH-1:0] center_x;
  logic [WORD_WIDTH-1:0] center_y;

  logic                        f_valid, f_ready;
  logic [LANES-1:0][NUM_W-1:0] f_num;
  logic [LANES-1:0][DEN_W-1:0] f_den;
  phj_side_t                   f_side;

  logic                        d_valid, d_ready;
  phj_quo_t [LANES-1:0]        d_quo;
  phj_side_t                   d_side;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      focal_x  <= FOCAL_X_RST;
      focal_y  <= FOCAL_Y_RST;
      center_x <= CENTER_X_RST;
      center_y <= CENTER_Y_RST;
    end else if (cfg.valid) begin
      case (phj_reg_t'(cfg.index))
        REG_FOCAL_X:  focal_x  <= cfg.data[FOCAL_W-1:0];
        REG_FOCAL_Y:  focal_y  <= cfg.data[FOCAL_W-1:0];
        REG_CENTER_X: center_x <= cfg.data;
        REG_CENTER_Y: center_y <= cfg.data;
        default: ;
      endcase
    end
  end

  phj_front u_front (
    .clk       (clk),
    .rst       (rst),
    .point     (point),
    .focal_x   (focal_x),
    .focal_y   (focal_y),
    .out_valid (f_valid),
    .out_ready (f_ready),
    .num       (f_num),
    .den       (f_den),
    .side      (f_side)
  );

  phj_div u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .num       (f_num),
    .den       (f_den),
    .in_side   (f_side),
    .out_valid (d_valid),
    .out_ready (d_ready),
    .quo       (d_quo),
    .out_side  (d_side)
  );

  phj_back u_back (
    .clk      (clk),
    .rst      (rst),
    .in_valid (d_valid),
    .in_ready (d_ready),
    .quo      (d_quo),
    .side     (d_side),
    .center_x (center_x),
    .center_y (center_y),
    .result   (result)
  );

endmodule
`default_nettype wire
